@@ rtl/lsmc_pkg.sv @@
// Package: shared constants, widths and types for the line sensor majority centroid unit.
package lsmc_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int WINDOW_LEN   = 5;
  localparam int NUM_POS_REGS = 5;
  localparam int RAW_W        = 8;
  localparam int POS_W        = 8;
  localparam int ERR_W        = 16;
  localparam int Q8_SHIFT     = 8;

  localparam int SEEN_W  = $clog2(WINDOW_LEN + 1);
  localparam int COUNT_W = $clog2(SENSOR_COUNT + 1);
  localparam int IDX_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int PIDX_W  = (NUM_POS_REGS > 1) ? $clog2(NUM_POS_REGS) : 1;
  localparam int SUM_W   = POS_W + COUNT_W;

  // divider: two quotient bits per step
  localparam int DIVIDEND_W = SUM_W + Q8_SHIFT;
  localparam int DIV_STEPS  = (DIVIDEND_W + 1) / 2;
  localparam int DIV_W      = 2 * DIV_STEPS;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } lsmc_div_status_t;

endpackage

@@ rtl/lsmc_if.sv @@
// Interfaces: input sample channel and result channel.
interface lsmc_in_if;
  import lsmc_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sensor_bits;

  modport source (output valid, output raw_sensor_bits, input ready);
  modport sink   (input valid, input raw_sensor_bits, output ready);
endinterface

interface lsmc_out_if;
  import lsmc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SENSOR_COUNT-1:0] voted_mask;
  logic signed [ERR_W-1:0] position_error_q8;
  logic                    line_lost;
  logic                    window_full;

  modport source (output valid, output voted_mask, output position_error_q8,
                  output line_lost, output window_full, input ready);
  modport sink   (input valid, input voted_mask, input position_error_q8,
                  input line_lost, input window_full, output ready);
endinterface

@@ rtl/line_sensor_majority_centroid_unit.sv @@
// Top level: sequencer, position registers, serial accumulate and result register.
//
//  channel  | dir | handshake     | payload
//  in_chan  | in  | valid/ready   | raw_sensor_bits[7:0]
//  out_chan | out | valid/ready   | voted_mask[4:0], position_error_q8[15:0], line_lost,
//           |     |               | window_full
//  cfg_*    | in  | cfg_we        | cfg_index[2:0], cfg_data[7:0]
//
// A sample passes from its request through the vote, the shared accumulator (one sensor
// at a time), the divide setup, the radix-4 divider (ten steps, then taking the quotient)
// and the result load; with no sensor voted the divide is skipped. in_chan is ready again
// the cycle after the result loads, so a new request is taken only once the last sample
// is through.
// Synchronous active-low reset clears the history windows, sample count, positions and
// control state. in_chan is ready only when the sequencer is idle; a result waiting on
// out_chan does not block the next request, only the loading of its own result.
module line_sensor_majority_centroid_unit
  import lsmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lsmc_in_if.sink           in_chan,
  lsmc_out_if.source        out_chan,
  input  logic              cfg_we,
  input  logic [PIDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VOTE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [POS_W-1:0]        pos_r [NUM_POS_REGS];
  logic [SENSOR_COUNT-1:0] voted_r;
  logic                    full_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [COUNT_W-1:0]      count_r;
  logic signed [ERR_W-1:0] err_r;

  logic                    out_valid_r;
  logic [SENSOR_COUNT-1:0] out_mask_r;
  logic signed [ERR_W-1:0] out_err_r;
  logic                    out_lost_r;
  logic                    out_full_r;

  logic [SENSOR_COUNT-1:0] voted;
  logic                    window_full;
  logic                    in_fire;
  logic                    out_load;
  logic signed [SUM_W-1:0] pos_cur;
  logic [SUM_W-1:0]        sum_mag;
  logic [DIV_W-1:0]        dividend;
  logic                    div_start;
  lsmc_div_status_t        div_st;
  logic [DIV_W-1:0]        quotient;
  logic [ERR_W-1:0]        quo_lo;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);
  assign div_start     = (state_r == S_DIVGO) && (count_r != '0);

  lsmc_vote u_vote (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_en    (in_fire),
    .sample      (in_chan.raw_sensor_bits[SENSOR_COUNT-1:0]),
    .voted       (voted),
    .window_full (window_full)
  );

  // sensors without a position register sit at 0 mm
  always_comb begin
    pos_cur = '0;
    if (32'(idx_r) < NUM_POS_REGS) begin
      pos_cur = SUM_W'(signed'(pos_r[idx_r[PIDX_W-1:0]]));
    end
  end

  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign dividend = DIV_W'({sum_mag, {Q8_SHIFT{1'b0}}});

  lsmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (count_r),
    .status   (div_st),
    .quotient (quotient)
  );

  assign quo_lo = quotient[ERR_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_VOTE;
      S_VOTE:  state_nxt = S_ACC;
      S_ACC:   if (idx_r == IDX_W'(SENSOR_COUNT - 1)) state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = (count_r != '0) ? S_DIV : S_DONE;
      S_DIV:   if (div_st.done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_POS_REGS; i++) pos_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
      if (cfg_we && (32'(cfg_index) < NUM_POS_REGS)) pos_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_VOTE: begin
        voted_r <= voted;
        full_r  <= window_full;
        idx_r   <= '0;
        sum_r   <= '0;
        count_r <= '0;
      end
      S_ACC: begin
        if (voted_r[idx_r]) begin
          sum_r   <= sum_r + pos_cur;
          count_r <= count_r + 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      S_DIVGO: err_r <= '0;
      S_DIV: begin
        if (div_st.done) err_r <= sum_r[SUM_W-1] ? ERR_W'(-quo_lo) : ERR_W'(quo_lo);
      end
      default: ;
    endcase
    if (out_load) begin
      out_mask_r <= voted_r;
      out_err_r  <= err_r;
      out_lost_r <= (voted_r == '0);
      out_full_r <= full_r;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.voted_mask        = out_mask_r;
  assign out_chan.position_error_q8 = out_err_r;
  assign out_chan.line_lost         = out_lost_r;
  assign out_chan.window_full       = out_full_r;

endmodule

@@ rtl/lsmc_vote.sv @@
// Sensor history windows, sample counter and majority vote.
module lsmc_vote
  import lsmc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    shift_en,
  input  logic [SENSOR_COUNT-1:0] sample,
  output logic [SENSOR_COUNT-1:0] voted,
  output logic                    window_full
);

  logic [WINDOW_LEN-1:0] window_r [SENSOR_COUNT];
  logic [SEEN_W-1:0]     seen_r;
  logic [SEEN_W-1:0]     threshold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) window_r[i] <= '0;
      seen_r <= '0;
    end else if (shift_en) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        window_r[i] <= {window_r[i][WINDOW_LEN-2:0], sample[i]};
      end
      if (seen_r < SEEN_W'(WINDOW_LEN)) seen_r <= seen_r + 1'b1;
    end
  end

  // with no samples every window is clear, so nothing votes
  assign threshold = (seen_r >> 1) + 1'b1;

  always_comb begin
    logic [SEEN_W-1:0] ones;
    voted = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      ones = '0;
      for (int b = 0; b < WINDOW_LEN; b++) ones = ones + SEEN_W'(window_r[i][b]);
      voted[i] = (ones >= threshold);
    end
  end

  assign window_full = (seen_r >= SEEN_W'(WINDOW_LEN));

endmodule

@@ rtl/lsmc_div.sv @@
// Radix-4 restoring divider: unsigned dividend by a small sensor count.
module lsmc_div
  import lsmc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [COUNT_W-1:0] divisor,
  output lsmc_div_status_t   status,
  output logic [DIV_W-1:0]   quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] den_r;
  logic [DIV_W-1:0]   quo_step;
  logic [COUNT_W-1:0] rem_step;

  // two dependent compare-subtract steps per cycle
  always_comb begin
    logic [COUNT_W:0] trial;
    quo_step = quo_r;
    rem_step = rem_r;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_step, quo_step[DIV_W-1]};
      quo_step = {quo_step[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        quo_step[0] = 1'b1;
      end
      rem_step = trial[COUNT_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DIV_STEPS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt  = quo_step;
      rem_nxt  = rem_step;
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= divisor;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the line sensor majority centroid unit: vote and centroid predictor.
module tb;
  import lsmc_pkg::*;

  localparam int     HALF_PERIOD_NS = 4;
  localparam int     RESET_CYCLES   = 11;
  localparam int     DRAIN_CYCLES   = 4;
  localparam int     SETTLE_CYCLES  = 40;
  localparam longint TIMEOUT_NS     = 10_000_000;
  localparam int     SPARE_W        = RAW_W - SENSOR_COUNT;

  typedef struct packed {
    logic [SENSOR_COUNT-1:0] voted_mask;
    logic signed [ERR_W-1:0] position_error_q8;
    logic                    line_lost;
    logic                    window_full;
  } centroid_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [PIDX_W-1:0] cfg_index;
  logic [POS_W-1:0]  cfg_data;

  lsmc_in_if  in_chan ();
  lsmc_out_if out_chan ();

  line_sensor_majority_centroid_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int tx_idle_pct;
  int rx_idle_pct;
  int mismatch_count;

  centroid_result_t pending_centroids[$];

  // shadow state of the filter and the position registers
  logic [WINDOW_LEN-1:0]   history_shadow [SENSOR_COUNT];
  logic [SEEN_W-1:0]       seen_shadow;
  logic signed [POS_W-1:0] pos_shadow [NUM_POS_REGS];

  // line shape for the tracking stimulus
  int line_centre;
  int line_width;

  always #HALF_PERIOD_NS clk = ~clk;

  function automatic centroid_result_t predict_centroid(input logic [RAW_W-1:0] raw);
    centroid_result_t r;
    int threshold;
    int active;
    int pos_sum;
    int quotient;
    r = '0;
    active = 0;
    pos_sum = 0;
    quotient = 0;
    for (int i = 0; i < SENSOR_COUNT; i++)
      history_shadow[i] = {history_shadow[i][WINDOW_LEN-2:0], raw[i]};
    if (seen_shadow < WINDOW_LEN)
      seen_shadow = seen_shadow + 1'b1;
    threshold = int'(seen_shadow) / 2 + 1;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if ($countones(history_shadow[i]) >= threshold) begin
        r.voted_mask[i] = 1'b1;
        active++;
        if (i < NUM_POS_REGS)
          pos_sum += int'(pos_shadow[i]);
      end
    end
    // signed divide truncates toward zero
    if (active != 0)
      quotient = (pos_sum * (1 << Q8_SHIFT)) / active;
    r.position_error_q8 = quotient[ERR_W-1:0];
    r.line_lost = (r.voted_mask == '0);
    r.window_full = (seen_shadow >= WINDOW_LEN);
    return r;
  endfunction

  task automatic send_sample(input logic [RAW_W-1:0] bits);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.raw_sensor_bits <= bits;
    do @(posedge clk); while (!in_chan.ready);
    pending_centroids.push_back(predict_centroid(bits));
  endtask

  task automatic wait_until_idle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_centroids.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [POS_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx[PIDX_W-1:0];
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_POS_REGS)
      pos_shadow[idx] = value;
    @(posedge clk);
  endtask

  task automatic program_positions(input bit extremes);
    logic [POS_W-1:0] value;
    wait_until_idle();
    for (int i = 0; i < NUM_POS_REGS; i++) begin
      if (extremes)
        value = $urandom_range(1) ? 8'sd127 : -8'sd128;
      else
        value = POS_W'($urandom_range(255));
      write_reg(i, value);
    end
  endtask

  // window filling from reset: thresholds grow with the sample count
  task automatic test_fill_window();
    send_sample(8'h1F);
    send_sample(8'h00);
    send_sample(8'h1F);
    send_sample(8'h1F);
    send_sample(8'h00);
    send_sample(8'hE0);
    send_sample(8'hFF);
  endtask

  task automatic test_position_extremes();
    wait_until_idle();
    write_reg(0, -8'sd128);
    write_reg(1, 8'sd127);
    write_reg(2, -8'sd128);
    write_reg(3, 8'sd127);
    write_reg(4, 8'sd0);
    // negative mean with a remainder
    repeat (3) send_sample(8'h1F);
    wait_until_idle();
    for (int i = 0; i < NUM_POS_REGS; i++) write_reg(i, -8'sd128);
    repeat (2) send_sample(8'h1F);
    wait_until_idle();
    for (int i = 0; i < NUM_POS_REGS; i++) write_reg(i, 8'sd127);
    repeat (2) send_sample(8'hFF);
    wait_until_idle();
    write_reg(0, 8'sd1);
    write_reg(1, 8'sd2);
    for (int i = 2; i < NUM_POS_REGS; i++) write_reg(i, 8'sd0);
    repeat (3) send_sample(8'h03);
  endtask

  // writes beyond the last position register must leave the positions alone
  task automatic test_ignored_index();
    wait_until_idle();
    for (int idx = NUM_POS_REGS; idx < (1 << PIDX_W); idx++)
      write_reg(idx, 8'hAA);
    repeat (2) send_sample(8'h15);
  endtask

  task automatic test_random_tracking(input int count);
    logic [RAW_W-1:0] bits;
    int step;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 25) begin
        bits = RAW_W'($urandom);
      end else begin
        if ($urandom_range(99) < 8) begin
          step = int'($urandom_range(2)) - 1;
          line_centre += step;
          if (line_centre < 0) line_centre = 0;
          if (line_centre > SENSOR_COUNT - 1) line_centre = SENSOR_COUNT - 1;
        end
        // width 0 gives a stretch with the line lost
        if ($urandom_range(99) < 5)
          line_width = $urandom_range(3);
        bits = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
          if (i >= line_centre && i < line_centre + line_width)
            bits[i] = 1'b1;
        if ($urandom_range(99) < 12)
          bits[$urandom_range(SENSOR_COUNT - 1)] ^= 1'b1;
        bits[RAW_W-1:SENSOR_COUNT] = SPARE_W'($urandom_range((1 << SPARE_W) - 1));
      end
      send_sample(bits);
    end
  endtask

  // receiver back-pressure
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    centroid_result_t got;
    centroid_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = {out_chan.voted_mask, out_chan.position_error_q8, out_chan.line_lost,
             out_chan.window_full};
      if (pending_centroids.size() == 0) begin
        $display("%0t: unexpected result: mask %b err %0d lost %b full %b", $time,
                 got.voted_mask, got.position_error_q8, got.line_lost, got.window_full);
        mismatch_count++;
      end else begin
        want = pending_centroids.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected %b/%0d/%b/%b, actual %b/%0d/%b/%b",
                   $time, want.voted_mask, want.position_error_q8, want.line_lost,
                   want.window_full, got.voted_mask, got.position_error_q8, got.line_lost,
                   got.window_full);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    mismatch_count = 0;
    tx_idle_pct = 31;
    rx_idle_pct = 51;
    line_centre = SENSOR_COUNT / 2;
    line_width = 1;
    for (int i = 0; i < SENSOR_COUNT; i++) history_shadow[i] = '0;
    for (int i = 0; i < NUM_POS_REGS; i++) pos_shadow[i] = '0;
    seen_shadow = '0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.raw_sensor_bits <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_fill_window();
    test_position_extremes();
    test_ignored_index();
    program_positions(1'b0);
    test_random_tracking(300);
    program_positions(1'b1);
    test_random_tracking(300);

    tx_idle_pct = 51;
    rx_idle_pct = 31;
    program_positions(1'b0);
    test_random_tracking(300);
    program_positions(1'b1);
    test_random_tracking(300);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_positions(1'b0);
    test_random_tracking(325);
    program_positions(1'b0);
    test_random_tracking(325);

    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_centroids.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
